// File: sv/assert_macros.svh
// Assertion macros used by the MDIO master top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition on every clock edge outside reset.
`define MDIO_ASSERT(label, cond) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error("mdio assertion failed");

// Check that a condition holds in the cycle after a trigger.
`define MDIO_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("mdio assertion failed");

`endif

// File: sv/mdio_c22_pkg.sv
// Types and constants shared by the MDIO clause 22 master modules.
package mdio_c22_pkg;

   // request mode codes on the input word
   localparam logic [1:0] MODE_READ  = 2'd1;
   localparam logic [1:0] MODE_WRITE = 2'd2;

   // configuration register indexes
   localparam logic [1:0] CSR_HALF_PERIOD  = 2'd0;
   localparam logic [1:0] CSR_PREAMBLE_LEN = 2'd1;
   localparam logic [1:0] CSR_PREAMBLE_WR  = 2'd2;

   // frame header fields
   localparam logic [3:0] START_OP_READ  = 4'b0110;
   localparam logic [3:0] START_OP_WRITE = 4'b0101;
   localparam logic [1:0] TA_WRITE       = 2'b10;

   // slot counts
   localparam logic [5:0] PREAMBLE_MAX     = 6'd32;
   localparam logic [5:0] READ_SHIFT_BITS  = 6'd14;
   localparam logic [5:0] WRITE_SHIFT_BITS = 6'd32;
   localparam logic [5:0] DATA_BITS        = 6'd16;
   localparam logic [5:0] SINGLE_SLOT      = 6'd1;

   // configuration reset values
   localparam logic [7:0] HALF_PERIOD_RESET = 8'd1;

   typedef enum logic [1:0] {
      CMD_TICK,
      CMD_READ,
      CMD_WRITE
   } cmd_kind_type;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_LEAD,
      PH_PRE,
      PH_SHIFT,
      PH_TA,
      PH_DATA,
      PH_TRAIL
   } phase_type;

   // classified word passed from the front to the sequencer
   typedef struct packed {
      cmd_kind_type kind;
      logic [31:0]  tx_word;
      logic         mdio_in;
   } cmd_type;

   typedef struct packed {
      logic [7:0] half_period_ticks;
      logic [5:0] preamble_length;
      logic       preamble_on_write;
   } cfg_type;

   typedef struct packed {
      logic        mdc;
      logic        mdio_out;
      logic        mdio_drive;
      logic        busy_res;
      logic [15:0] read_data;
      logic        read_done;
      logic        request_rejected;
   } rsp_type;

endpackage

// File: sv/mdio_clause22_master.sv
// Clause 22 MDIO master advanced by tick words. Every input word (a tick, a read
// request or a write request) yields exactly one result word with the MDC and MDIO
// pin levels after that tick. A word passes a classifying input register, a
// two-entry queue and the frame sequencer, whose step is held in the result
// register; the sustained rate is one word per cycle while the result side is
// ready. MDC runs at half_period_ticks ticks per half period; requests that arrive
// while a frame is running are dropped and flagged with request_rejected. The user
// must write registers through the csr port only while no word is in flight; the
// block does not enforce this.
`include "assert_macros.svh"

module mdio_clause22_master (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_write_data,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_mode,
   input  logic [4:0]  req_phy_address,
   input  logic [4:0]  req_register_address,
   input  logic [15:0] req_write_data,
   input  logic        req_mdio_in,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_mdc,
   output logic        rsp_mdio_out,
   output logic        rsp_mdio_drive,
   output logic        rsp_busy_res,
   output logic [15:0] rsp_read_data,
   output logic        rsp_read_done,
   output logic        rsp_request_rejected
);
   import mdio_c22_pkg::*;

   cfg_type cfg_ff, cfg_in;
   logic    push_valid, push_ready;
   cmd_type push_cmd;
   logic    pop_valid, pop_ready;
   cmd_type pop_cmd;
   rsp_type rsp;

   assign csr_ready = 1'b1;

   // decode configuration writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_HALF_PERIOD:  cfg_in.half_period_ticks = csr_write_data;
            CSR_PREAMBLE_LEN: cfg_in.preamble_length   = csr_write_data[5:0];
            CSR_PREAMBLE_WR:  cfg_in.preamble_on_write = csr_write_data[0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.half_period_ticks <= HALF_PERIOD_RESET;
         cfg_ff.preamble_length   <= PREAMBLE_MAX;
         cfg_ff.preamble_on_write <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   mdio_c22_front u_front (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_mode             (req_mode),
      .req_phy_address      (req_phy_address),
      .req_register_address (req_register_address),
      .req_write_data       (req_write_data),
      .req_mdio_in          (req_mdio_in),
      .push_valid           (push_valid),
      .push_ready           (push_ready),
      .push_cmd             (push_cmd)
   );

   mdio_c22_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_cmd    (pop_cmd)
   );

   mdio_c22_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .cmd_valid (pop_valid),
      .cmd_ready (pop_ready),
      .cmd       (pop_cmd),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp       (rsp)
   );

   // split the result word onto its ports
   assign rsp_mdc              = rsp.mdc;
   assign rsp_mdio_out         = rsp.mdio_out;
   assign rsp_mdio_drive       = rsp.mdio_drive;
   assign rsp_busy_res         = rsp.busy_res;
   assign rsp_read_data        = rsp.read_data;
   assign rsp_read_done        = rsp.read_done;
   assign rsp_request_rejected = rsp.request_rejected;

   // released MDIO carries a low level
   `MDIO_ASSERT(a_released_low, !(rsp_valid && !rsp_mdio_drive && rsp_mdio_out))
   // a completed read leaves the master idle
   `MDIO_ASSERT(a_done_idle, !(rsp_valid && rsp_read_done && rsp_busy_res))
   // MDC idles high
   `MDIO_ASSERT(a_idle_mdc_high, !(rsp_valid && !rsp_busy_res && !rsp_mdc))
   // a word taken by the sequencer shows up as a result on the next cycle
   `MDIO_ASSERT_NEXT(a_step_result, pop_valid && pop_ready, rsp_valid)

endmodule

// File: sv/mdio_c22_front.sv
// Front stage: accept request words, classify them and build the frame header.
module mdio_c22_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [1:0]            req_mode,
   input  logic [4:0]            req_phy_address,
   input  logic [4:0]            req_register_address,
   input  logic [15:0]           req_write_data,
   input  logic                  req_mdio_in,
   output logic                  push_valid,
   input  logic                  push_ready,
   output mdio_c22_pkg::cmd_type push_cmd
);
   import mdio_c22_pkg::*;

   logic    valid_ff, valid_in;
   cmd_type cmd_ff, cmd_in;
   logic    accept;

   assign req_ready  = !valid_ff || push_ready;
   assign accept     = req_valid && req_ready;
   assign push_valid = valid_ff;
   assign push_cmd   = cmd_ff;

   // classify the incoming word and build the shift word of its frame
   always_comb begin
      cmd_in.mdio_in = req_mdio_in;
      case (req_mode)
         MODE_READ: begin
            cmd_in.kind    = CMD_READ;
            cmd_in.tx_word = {START_OP_READ, req_phy_address, req_register_address, 18'd0};
         end
         MODE_WRITE: begin
            cmd_in.kind    = CMD_WRITE;
            cmd_in.tx_word = {START_OP_WRITE, req_phy_address, req_register_address,
                              TA_WRITE, req_write_data};
         end
         default: begin
            cmd_in.kind    = CMD_TICK;
            cmd_in.tx_word = 32'd0;
         end
      endcase
   end

   // hold the word until the queue takes it
   always_comb begin
      valid_in = valid_ff;
      if (accept) begin
         valid_in = 1'b1;
      end else if (push_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff <= cmd_in;
      end
   end

endmodule

// File: sv/mdio_c22_queue.sv
// Two-entry queue between the front stage and the frame sequencer.
module mdio_c22_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push_valid,
   output logic                  push_ready,
   input  mdio_c22_pkg::cmd_type push_cmd,
   output logic                  pop_valid,
   input  logic                  pop_ready,
   output mdio_c22_pkg::cmd_type pop_cmd
);
   import mdio_c22_pkg::*;

   cmd_type    entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push, pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_cmd    = entry_ff[rd_ptr_ff];

   // advance pointers and occupancy
   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// File: sv/mdio_c22_engine.sv
// Frame sequencer: one step per word, MDC divider, shift registers, result register.
module mdio_c22_engine (
   input  logic                  clock,
   input  logic                  reset,
   input  mdio_c22_pkg::cfg_type cfg,
   input  logic                  cmd_valid,
   output logic                  cmd_ready,
   input  mdio_c22_pkg::cmd_type cmd,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output mdio_c22_pkg::rsp_type rsp
);
   import mdio_c22_pkg::*;

   phase_type   phase_ff, phase_in;
   logic [5:0]  count_ff, count_in;
   logic [7:0]  tdiv_ff, tdiv_in;
   logic        clk_ff, clk_in;
   logic        data_ff, data_in;
   logic        is_read_ff, is_read_in;
   logic [31:0] tx_ff, tx_in;
   logic [15:0] rx_ff, rx_in;
   logic [15:0] held_ff, held_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_ff, rsp_in;

   logic        step;
   logic        request;
   logic        rejected, done;
   logic        enter;
   phase_type   target;
   logic [7:0]  half;
   logic [7:0]  tdiv_next;
   logic [5:0]  count_dec;
   logic [5:0]  pre_len;
   logic        drive;

   assign cmd_ready = !rsp_valid_ff || rsp_ready;
   assign step      = cmd_valid && cmd_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   assign request   = (cmd.kind == CMD_READ) || (cmd.kind == CMD_WRITE);
   assign half      = (cfg.half_period_ticks == 8'd0) ? 8'd1 : cfg.half_period_ticks;
   assign tdiv_next = tdiv_ff + 8'd1;
   assign count_dec = (count_ff != 6'd0) ? count_ff - 6'd1 : 6'd0;
   assign pre_len   = (cfg.preamble_length > PREAMBLE_MAX) ? PREAMBLE_MAX
                                                          : cfg.preamble_length;

   // next state of the sequencer for one word
   always_comb begin
      phase_in   = phase_ff;
      count_in   = count_ff;
      tdiv_in    = tdiv_ff;
      clk_in     = clk_ff;
      data_in    = data_ff;
      is_read_in = is_read_ff;
      tx_in      = tx_ff;
      rx_in      = rx_ff;
      held_in    = held_ff;
      rejected   = 1'b0;
      done       = 1'b0;
      enter      = 1'b0;
      target     = PH_IDLE;

      if (phase_ff == PH_IDLE) begin
         // start a frame on a request
         if (request) begin
            is_read_in = (cmd.kind == CMD_READ);
            tdiv_in    = 8'd0;
            clk_in     = 1'b0;
            tx_in      = cmd.tx_word;
            enter      = 1'b1;
            if (cmd.kind == CMD_READ) begin
               target = PH_LEAD;
            end else if (cfg.preamble_on_write) begin
               target = PH_PRE;
            end else begin
               target = PH_SHIFT;
            end
         end
      end else begin
         rejected = request;
         tdiv_in  = tdiv_next;
         if (tdiv_next >= half) begin
            tdiv_in = 8'd0;
            if (!clk_ff) begin
               // rising MDC: sample read data
               clk_in = 1'b1;
               if (phase_ff == PH_DATA) begin
                  rx_in = {rx_ff[14:0], cmd.mdio_in};
               end
            end else begin
               // end of a bit slot
               if (phase_ff == PH_SHIFT) begin
                  tx_in = {tx_ff[30:0], 1'b0};
               end
               count_in = count_dec;
               clk_in   = 1'b0;
               if (count_dec != 6'd0) begin
                  if (phase_ff == PH_SHIFT) begin
                     data_in = tx_ff[30];
                  end
               end else begin
                  case (phase_ff)
                     PH_LEAD: begin
                        enter  = 1'b1;
                        target = PH_PRE;
                     end
                     PH_PRE: begin
                        enter  = 1'b1;
                        target = PH_SHIFT;
                     end
                     PH_SHIFT: begin
                        if (is_read_ff) begin
                           enter  = 1'b1;
                           target = PH_TA;
                        end
                     end
                     PH_TA: begin
                        enter  = 1'b1;
                        target = PH_DATA;
                     end
                     PH_DATA: begin
                        enter  = 1'b1;
                        target = PH_TRAIL;
                     end
                     default: begin
                     end
                  endcase
                  // close the frame
                  if (!enter) begin
                     done = (phase_ff == PH_TRAIL);
                     if (done) begin
                        held_in = rx_ff;
                     end
                     phase_in = PH_IDLE;
                     count_in = 6'd0;
                     clk_in   = 1'b1;
                     data_in  = 1'b0;
                  end
               end
            end
         end
      end

      // load the slot count and data level of a new segment
      if (enter) begin
         if ((target == PH_PRE) && (pre_len != 6'd0)) begin
            phase_in = PH_PRE;
            count_in = pre_len;
            data_in  = 1'b1;
         end else begin
            phase_in = (target == PH_PRE) ? PH_SHIFT : target;
            data_in  = 1'b0;
            case (phase_in)
               PH_SHIFT: begin
                  count_in = is_read_in ? READ_SHIFT_BITS : WRITE_SHIFT_BITS;
                  data_in  = tx_in[31];
               end
               PH_DATA: begin
                  count_in = DATA_BITS;
               end
               default: begin
                  count_in = SINGLE_SLOT;
               end
            endcase
         end
      end
   end

   // form the result word
   always_comb begin
      drive                   = (phase_in == PH_PRE) || (phase_in == PH_SHIFT);
      rsp_in.mdc              = clk_in;
      rsp_in.mdio_out         = drive && data_in;
      rsp_in.mdio_drive       = drive;
      rsp_in.busy_res         = (phase_in != PH_IDLE);
      rsp_in.read_data        = held_in;
      rsp_in.read_done        = done;
      rsp_in.request_rejected = rejected;
      rsp_valid_in            = step || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         count_ff     <= 6'd0;
         tdiv_ff      <= 8'd0;
         clk_ff       <= 1'b1;
         data_ff      <= 1'b0;
         is_read_ff   <= 1'b0;
         tx_ff        <= 32'd0;
         rx_ff        <= 16'd0;
         held_ff      <= 16'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (step) begin
            phase_ff   <= phase_in;
            count_ff   <= count_in;
            tdiv_ff    <= tdiv_in;
            clk_ff     <= clk_in;
            data_ff    <= data_in;
            is_read_ff <= is_read_in;
            tx_ff      <= tx_in;
            rx_ff      <= rx_in;
            held_ff    <= held_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

// File: sv/mdio_c22_master.sv
// The clause 22 MDIO master top level (configuration registers, front, queue, sequencer) is in mdio_clause22_master.sv.

// File: dv/tb_mdio_clause22_master.sv
// Testbench for the clause 22 MDIO master: random and directed tick words with a pin predictor.
`timescale 1ns / 1ps

module tb_mdio_clause22_master;
   import mdio_c22_pkg::*;

   localparam logic [1:0] MODE_TICK  = 2'd0;
   localparam logic [1:0] MODE_SPARE = 2'd3;
   localparam int HOLD_OFF_CYCLES = 200;
   localparam int RANDOM_WORDS    = 150;
   localparam int SETTLE_CYCLES   = 8;
   localparam int MDIN_ZEROS      = 0;
   localparam int MDIN_ONES       = 1;
   localparam int MDIN_RANDOM     = 2;

   logic        clock = 1'b0;
   logic        reset;
   logic        csr_valid;
   logic        csr_ready;
   logic [1:0]  csr_index;
   logic [7:0]  csr_write_data;
   logic        req_valid;
   logic        req_ready;
   logic [1:0]  req_mode;
   logic [4:0]  req_phy_address;
   logic [4:0]  req_register_address;
   logic [15:0] req_write_data;
   logic        req_mdio_in;
   logic        rsp_valid;
   logic        rsp_ready;
   logic        rsp_mdc;
   logic        rsp_mdio_out;
   logic        rsp_mdio_drive;
   logic        rsp_busy_res;
   logic [15:0] rsp_read_data;
   logic        rsp_read_done;
   logic        rsp_request_rejected;

   mdio_clause22_master uut (
      .clock                (clock),
      .reset                (reset),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_index            (csr_index),
      .csr_write_data       (csr_write_data),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_mode             (req_mode),
      .req_phy_address      (req_phy_address),
      .req_register_address (req_register_address),
      .req_write_data       (req_write_data),
      .req_mdio_in          (req_mdio_in),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_mdc              (rsp_mdc),
      .rsp_mdio_out         (rsp_mdio_out),
      .rsp_mdio_drive       (rsp_mdio_drive),
      .rsp_busy_res         (rsp_busy_res),
      .rsp_read_data        (rsp_read_data),
      .rsp_read_done        (rsp_read_done),
      .rsp_request_rejected (rsp_request_rejected)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // pin sequencer mirror
   phase_type   seq_phase     = PH_IDLE;
   logic [5:0]  slot_count    = '0;
   logic [7:0]  div_count     = '0;
   logic        mdc_level     = 1'b1;
   logic        mdio_level    = 1'b0;
   logic        frame_is_read = 1'b0;
   logic [31:0] tx_shift      = '0;
   logic [15:0] rx_shift      = '0;
   logic [15:0] last_read     = '0;
   logic [7:0]  cfg_half      = HALF_PERIOD_RESET;
   logic [5:0]  cfg_pre_len   = PREAMBLE_MAX;
   logic        cfg_pre_wr    = 1'b0;

   rsp_type pin_words_due[$];
   int      fail_count   = 0;
   int      words_sent   = 0;
   bit      idling_on    = 1'b1;
   bit      hold_off_req = 1'b0;

   // Enter a frame segment; an empty preamble falls through to the header.
   function automatic void load_phase(input phase_type ph);
      phase_type  target;
      logic [5:0] pre_slots;
      target = ph;
      pre_slots = (cfg_pre_len > PREAMBLE_MAX) ? PREAMBLE_MAX : cfg_pre_len;
      if (target == PH_PRE && pre_slots == 6'd0)
         target = PH_SHIFT;
      seq_phase = target;
      mdio_level = 1'b0;
      case (target)
         PH_PRE: begin
            slot_count = pre_slots;
            mdio_level = 1'b1;
         end
         PH_SHIFT: begin
            slot_count = frame_is_read ? READ_SHIFT_BITS : WRITE_SHIFT_BITS;
            mdio_level = tx_shift[31];
         end
         PH_DATA: slot_count = DATA_BITS;
         default: slot_count = SINGLE_SLOT;
      endcase
   endfunction

   // Close a bit slot at the end of its high half; returns 1 when a read completes.
   function automatic logic finish_slot();
      logic done;
      done = 1'b0;
      if (seq_phase == PH_SHIFT)
         tx_shift = tx_shift << 1;
      if (slot_count != 6'd0)
         slot_count = slot_count - 6'd1;
      mdc_level = 1'b0;
      if (slot_count != 6'd0) begin
         if (seq_phase == PH_SHIFT)
            mdio_level = tx_shift[31];
         return 1'b0;
      end
      case (seq_phase)
         PH_LEAD: begin
            load_phase(PH_PRE);
            return 1'b0;
         end
         PH_PRE: begin
            load_phase(PH_SHIFT);
            return 1'b0;
         end
         PH_SHIFT: begin
            if (frame_is_read) begin
               load_phase(PH_TA);
               return 1'b0;
            end
         end
         PH_TA: begin
            load_phase(PH_DATA);
            return 1'b0;
         end
         PH_DATA: begin
            load_phase(PH_TRAIL);
            return 1'b0;
         end
         default: ;
      endcase
      done = (seq_phase == PH_TRAIL);
      if (done)
         last_read = rx_shift;
      seq_phase = PH_IDLE;
      slot_count = 6'd0;
      mdc_level = 1'b1;
      mdio_level = 1'b0;
      return done;
   endfunction

   // Advance the mirror by one tick word and return the pin word it yields.
   function automatic rsp_type next_pin_word(input logic [1:0] mode, input logic [4:0] phy,
                                             input logic [4:0] regaddr,
                                             input logic [15:0] wdata, input logic mdin);
      rsp_type    w;
      logic [7:0] half;
      logic       request;
      logic       rejected;
      logic       done;
      logic       drive;
      half = (cfg_half == 8'd0) ? 8'd1 : cfg_half;
      request = (mode == MODE_READ || mode == MODE_WRITE);
      rejected = 1'b0;
      done = 1'b0;
      if (seq_phase == PH_IDLE) begin
         if (request) begin
            frame_is_read = (mode == MODE_READ);
            div_count = 8'd0;
            mdc_level = 1'b0;
            if (frame_is_read) begin
               tx_shift = {START_OP_READ, phy, regaddr, 18'd0};
               load_phase(PH_LEAD);
            end else begin
               tx_shift = {START_OP_WRITE, phy, regaddr, TA_WRITE, wdata};
               load_phase(cfg_pre_wr ? PH_PRE : PH_SHIFT);
            end
         end
      end else begin
         rejected = request;
         div_count = div_count + 8'd1;
         if (div_count >= half) begin
            div_count = 8'd0;
            if (!mdc_level) begin
               mdc_level = 1'b1;
               if (seq_phase == PH_DATA)
                  rx_shift = {rx_shift[14:0], mdin};
            end else begin
               done = finish_slot();
            end
         end
      end
      drive = (seq_phase == PH_PRE || seq_phase == PH_SHIFT);
      w.mdc = mdc_level;
      w.mdio_out = drive & mdio_level;
      w.mdio_drive = drive;
      w.busy_res = (seq_phase != PH_IDLE);
      w.read_data = last_read;
      w.read_done = done;
      w.request_rejected = rejected;
      return w;
   endfunction

   function automatic void compare_field(input string label, input logic [15:0] want,
                                         input logic [15:0] got);
      if (want !== got) begin
         $display("%0t: %s expected %0h actual %0h", $time, label, want, got);
         fail_count++;
      end
   endfunction

   // Check each result word against the oldest prediction.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pin_words_due.size() == 0) begin
            $display("%0t: result word expected none actual mdc %0b mdio %0b busy %0b",
                     $time, rsp_mdc, rsp_mdio_out, rsp_busy_res);
            fail_count++;
         end else begin
            want = pin_words_due.pop_front();
            compare_field("mdc", 16'(want.mdc), 16'(rsp_mdc));
            compare_field("mdio_out", 16'(want.mdio_out), 16'(rsp_mdio_out));
            compare_field("mdio_drive", 16'(want.mdio_drive), 16'(rsp_mdio_drive));
            compare_field("busy_res", 16'(want.busy_res), 16'(rsp_busy_res));
            compare_field("read_data", want.read_data, rsp_read_data);
            compare_field("read_done", 16'(want.read_done), 16'(rsp_read_done));
            compare_field("request_rejected", 16'(want.request_rejected),
                          16'(rsp_request_rejected));
         end
      end
   end

   // Result side: random stall bursts, plus one long hold-off on request.
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            rsp_ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
            rsp_ready <= 1'b1;
         end else if (idling_on && $urandom_range(0, 7) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clock);
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Offer one tick word, hold it until accepted, then record its prediction.
   task automatic send_word(input logic [1:0] mode, input logic [4:0] phy,
                            input logic [4:0] regaddr, input logic [15:0] wdata,
                            input logic mdin);
      if (idling_on && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_mode <= mode;
      req_phy_address <= phy;
      req_register_address <= regaddr;
      req_write_data <= wdata;
      req_mdio_in <= mdin;
      do @(posedge clock); while (!req_ready);
      pin_words_due.push_back(next_pin_word(mode, phy, regaddr, wdata, mdin));
      words_sent++;
   endtask

   task automatic send_tick(input logic mdin);
      send_word(MODE_TICK, 5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)),
                16'($urandom_range(0, 65535)), mdin);
   endtask

   // Drain all words, then write one register.
   task automatic write_csr(input logic [1:0] index, input logic [7:0] data);
      req_valid <= 1'b0;
      while (pin_words_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_write_data <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (index)
         CSR_HALF_PERIOD:  cfg_half = data;
         CSR_PREAMBLE_LEN: cfg_pre_len = data[5:0];
         CSR_PREAMBLE_WR:  cfg_pre_wr = data[0];
         default: ;
      endcase
   endtask

   task automatic start_frame(input logic [1:0] mode, input logic [4:0] phy,
                              input logic [4:0] regaddr, input logic [15:0] wdata);
      send_word(mode, phy, regaddr, wdata, 1'($urandom_range(0, 1)));
   endtask

   // Tick until the frame ends, with stray requests at the given percentage.
   task automatic finish_frame(input int stray_pct, input int mdin_pick);
      logic [1:0] mode;
      logic       mdin;
      while (seq_phase != PH_IDLE) begin
         if (mdin_pick == MDIN_RANDOM)
            mdin = 1'($urandom_range(0, 1));
         else
            mdin = (mdin_pick == MDIN_ONES);
         if ($urandom_range(0, 99) < stray_pct) begin
            mode = 2'($urandom_range(1, 3));
            send_word(mode, 5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)),
                      16'($urandom_range(0, 65535)), mdin);
         end else begin
            send_tick(mdin);
         end
      end
   endtask

   task automatic random_frame(input int stray_pct);
      start_frame($urandom_range(0, 1) ? MODE_READ : MODE_WRITE, 5'($urandom_range(0, 31)),
                  5'($urandom_range(0, 31)), 16'($urandom_range(0, 65535)));
      finish_frame(stray_pct, MDIN_RANDOM);
   endtask

   task automatic test_idle_words;
      send_word(MODE_TICK, 5'h1f, 5'h1f, 16'hffff, 1'b1);
      send_word(MODE_SPARE, 5'h00, 5'h00, 16'h0000, 1'b0);
      send_word(MODE_SPARE, 5'h1f, 5'h1f, 16'hffff, 1'b1);
      send_word(MODE_TICK, 5'h00, 5'h00, 16'h0000, 1'b0);
   endtask

   // Default preamble reads, all-ones and all-zeros data.
   task automatic test_read_frames;
      start_frame(MODE_READ, 5'h1f, 5'h00, 16'h0000);
      finish_frame(0, MDIN_ONES);
      start_frame(MODE_READ, 5'h00, 5'h1f, 16'hffff);
      finish_frame(0, MDIN_ZEROS);
   endtask

   task automatic test_write_frames;
      start_frame(MODE_WRITE, 5'h00, 5'h1f, 16'hffff);
      finish_frame(0, MDIN_RANDOM);
      start_frame(MODE_WRITE, 5'h1f, 5'h00, 16'h0000);
      finish_frame(0, MDIN_RANDOM);
   endtask

   // Requests while a frame runs are dropped and flagged; the spare mode acts as a tick.
   task automatic test_busy_requests;
      start_frame(MODE_WRITE, 5'h15, 5'h0a, 16'ha5a5);
      send_word(MODE_READ, 5'h0a, 5'h15, 16'h5a5a, 1'b1);
      send_word(MODE_WRITE, 5'h1f, 5'h1f, 16'hffff, 1'b0);
      send_word(MODE_SPARE, 5'h00, 5'h00, 16'h0000, 1'b1);
      finish_frame(0, MDIN_RANDOM);
   endtask

   // Preamble on writes, empty preamble, and an oversized length that saturates.
   task automatic test_preamble_settings;
      write_csr(CSR_PREAMBLE_WR, 8'd1);
      write_csr(CSR_PREAMBLE_LEN, 8'd0);
      start_frame(MODE_WRITE, 5'h12, 5'h05, 16'h1234);
      finish_frame(0, MDIN_RANDOM);
      start_frame(MODE_READ, 5'h05, 5'h12, 16'h0000);
      finish_frame(0, MDIN_RANDOM);
      write_csr(CSR_PREAMBLE_LEN, 8'hff);
      start_frame(MODE_WRITE, 5'h0c, 5'h13, 16'hc3c3);
      finish_frame(0, MDIN_RANDOM);
      write_csr(CSR_PREAMBLE_LEN, 8'd32);
      write_csr(CSR_PREAMBLE_WR, 8'd0);
   endtask

   // Zero half period, slowest clock, and live changes of rate and preamble mid-frame.
   task automatic test_half_period;
      write_csr(CSR_HALF_PERIOD, 8'd0);
      start_frame(MODE_WRITE, 5'h03, 5'h1c, 16'h3c3c);
      finish_frame(0, MDIN_RANDOM);
      write_csr(CSR_HALF_PERIOD, 8'd255);
      start_frame(MODE_READ, 5'h1c, 5'h03, 16'h0000);
      repeat (300) send_tick(1'($urandom_range(0, 1)));
      write_csr(CSR_PREAMBLE_LEN, 8'd3);
      write_csr(CSR_HALF_PERIOD, 8'd1);
      finish_frame(0, MDIN_RANDOM);
   endtask

   // Stall the result side long enough for the block to back up its input.
   task automatic test_back_pressure;
      hold_off_req = 1'b1;
      random_frame(5);
   endtask

   task automatic test_random_frames;
      int stop_at;
      int pick;
      stop_at = words_sent + RANDOM_WORDS;
      while (words_sent < stop_at) begin
         // change one register now and then, mostly toward short frames
         if ($urandom_range(0, 3) == 0) begin
            pick = $urandom_range(0, 99);
            case ($urandom_range(0, 2))
               0: write_csr(CSR_HALF_PERIOD, (pick < 65) ? 8'd1 : (pick < 85) ? 8'd2 :
                            (pick < 97) ? 8'($urandom_range(3, 6)) : 8'd0);
               1: write_csr(CSR_PREAMBLE_LEN, (pick < 70) ? 8'($urandom_range(0, 8)) :
                            8'($urandom_range(9, 255)));
               default: write_csr(CSR_PREAMBLE_WR, 8'($urandom_range(0, 1)));
            endcase
         end
         repeat ($urandom_range(0, 2))
            send_word($urandom_range(0, 1) ? MODE_TICK : MODE_SPARE,
                      5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)),
                      16'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)));
         random_frame(4);
      end
   endtask

   task automatic test_quiet_tail;
      idling_on = 1'b0;
      repeat (2) random_frame(4);
   endtask

   initial begin
      reset = 1'b1;
      csr_valid = 1'b0;
      csr_index = CSR_HALF_PERIOD;
      csr_write_data = 8'd0;
      req_valid = 1'b0;
      req_mode = MODE_TICK;
      req_phy_address = 5'd0;
      req_register_address = 5'd0;
      req_write_data = 16'd0;
      req_mdio_in = 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      test_idle_words();
      test_read_frames();
      test_write_frames();
      test_busy_requests();
      test_preamble_settings();
      test_half_period();
      test_back_pressure();
      test_random_frames();
      test_quiet_tail();

      // drain, then allow stray words to show up
      req_valid <= 1'b0;
      while (pin_words_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

   initial begin
      #4_000_000;
      $display("FAILURE");
      $finish;
   end

endmodule
